/* hdl/lpht_pkg.sv */
package lpht_pkg;

  localparam int DefCapacity  = 64;
  localparam int DefKeyChars  = 8;
  localparam int DefValueBits = 32;

  localparam int KindW   = 3;
  localparam int KeyW    = 64;
  localparam int ValueW  = 32;
  localparam int SlotW   = 6;
  localparam int StatusW = 2;
  localparam int SizeW   = 7;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT  = 3'd0,
    KIND_LOOKUP  = 3'd1,
    KIND_DEL_KEY = 3'd2,
    KIND_READ    = 3'd3,
    KIND_DEL_SLOT = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_FULL    = 2'd2,
    ST_PRESENT = 2'd3
  } status_e;

  // start / done handshake between the sequencer and the hash unit
  typedef struct packed {
    logic start;
    logic done;
  } hash_ctl_t;

endpackage

/* hdl/lpht_if.sv */
interface lpht_req_if;
  import lpht_pkg::*;
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [KeyW-1:0]    key;
  logic [ValueW-1:0]  value;
  logic [SlotW-1:0]   slot;
  modport source (output valid, kind, key, value, slot, input ready);
  modport sink   (input valid, kind, key, value, slot, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SlotW-1:0]   found_slot;
  logic [ValueW-1:0]  read_value;
  logic [SizeW-1:0]   entry_total;
  logic               is_empty;
  modport source (output valid, status, found_slot, read_value, entry_total, is_empty,
                  input ready);
  modport sink   (input valid, status, found_slot, read_value, entry_total, is_empty,
                  output ready);
endinterface

/* hdl/linear_probe_hash_table.sv */
// Sequence: key operations hash the key, then read and check one slot per probe
//   step (at most active size + 1 steps) before the result is offered; slot
//   operations read the slot; a full-table insert or unknown kind answers at once.
// Flow: one transaction at a time; the next is accepted back in idle, after
//   the result is taken.
// Reset: all slots free, count zero, table_size 64. A table_size write
//   frees every slot at once through the per-slot used bits.
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int Capacity  = DefCapacity,
  parameter int KeyChars  = DefKeyChars,
  parameter int ValueBits = DefValueBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SizeW-1:0]    cfg_wdata_i,
  lpht_req_if.sink            req,
  lpht_rsp_if.source          rsp
);
  localparam int SzW = $clog2(Capacity+1);
  localparam int IxW = (Capacity > 1) ? $clog2(Capacity) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_RSP   = 3'd4;
  localparam logic [2:0] S_SLOT  = 3'd5;

  logic [2:0]           state_q;
  logic [SizeW-1:0]     tsize_q;
  logic [Capacity-1:0]  used_q;
  logic [SzW-1:0]       count_q;
  logic [KindW-1:0]     kind_q;
  logic [KeyW-1:0]      key_q;
  logic [ValueBits-1:0] val_q;
  logic [SlotW-1:0]     slot_q;
  logic [IxW-1:0]       idx_q;
  logic [SzW-1:0]       n_q;
  logic [StatusW-1:0]   st_q;
  logic [SlotW-1:0]     fs_q;
  logic [ValueW-1:0]    rv_q;

  logic [KeyW-1:0]      key_mem [Capacity];
  logic [ValueBits-1:0] val_mem [Capacity];
  logic [KeyW-1:0]      rd_key_q;
  logic [ValueBits-1:0] rd_val_q;

  logic [SzW-1:0] size;
  logic [KeyW-1:0] ckey;
  logic [SzW-1:0] home;
  logic            hdone;
  logic            hash_done;
  hash_ctl_t       hctl;
  logic            wr_en;

  always_comb begin
    if (tsize_q == '0) size = SzW'(1);
    else if (32'(tsize_q) > Capacity) size = SzW'(Capacity);
    else size = SzW'(tsize_q);
  end

  always_comb begin
    logic stop;
    stop = 1'b0;
    ckey = '0;
    for (int i = 0; i < 8; i++) begin
      if (req.key[8*i +: 8] == 8'd0 || i >= KeyChars) stop = 1'b1;
      if (!stop) ckey[8*i +: 8] = req.key[8*i +: 8];
    end
  end

  assign hctl.start = (state_q == S_IDLE) && req.valid && req.ready &&
                      (req.kind == KIND_INSERT || req.kind == KIND_LOOKUP ||
                       req.kind == KIND_DEL_KEY) &&
                      !(req.kind == KIND_INSERT && count_q >= size);
  assign hctl.done  = hdone;

  lpht_hash #(.KeyChars(KeyChars), .Capacity(Capacity)) u_hash (
    .clk_i, .rst_ni, .start_i(hctl.start), .key_i(ckey), .size_i(size),
    .done_o(hash_done), .home_o(home)
  );
  assign hdone = (state_q == S_HASH) && hash_done;

  assign req.ready = (state_q == S_IDLE) && !cfg_we_i;
  assign rsp.valid = (state_q == S_RSP);
  assign rsp.status = st_q;
  assign rsp.found_slot = fs_q;
  assign rsp.read_value = rv_q;
  assign rsp.entry_total = SizeW'(count_q);
  assign rsp.is_empty = (count_q == '0);

  logic [IxW-1:0] rd_addr;
  logic [IxW-1:0] nxt_idx;
  assign rd_addr = (state_q == S_IDLE) ? IxW'(req.slot) : idx_q;
  assign nxt_idx = (32'(idx_q) + 1 >= 32'(size)) ? '0 : IxW'(32'(idx_q) + 1);
  assign wr_en = (state_q == S_CHK) && (kind_q == KIND_INSERT) && !used_q[idx_q] &&
                 (n_q < size);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[idx_q] <= key_q;
      val_mem[idx_q] <= val_q;
    end
    rd_key_q <= key_mem[rd_addr];
    rd_val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tsize_q <= SizeW'(64);
      used_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      tsize_q <= cfg_wdata_i;
      used_q  <= '0;
      count_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            kind_q <= req.kind;
            key_q  <= ckey;
            val_q  <= ValueBits'(req.value);
            slot_q <= req.slot;
            st_q   <= ST_MISS;
            fs_q   <= '0;
            rv_q   <= '0;
            if (hctl.start) begin
              state_q <= S_HASH;
            end else if (req.kind == KIND_INSERT) begin
              st_q    <= ST_FULL;
              state_q <= S_RSP;
            end else if (req.kind == KIND_READ || req.kind == KIND_DEL_SLOT) begin
              state_q <= S_SLOT;
            end else begin
              state_q <= S_RSP;
            end
          end
        end
        S_HASH: begin
          // hold until the hash unit reports its remainder
          if (hctl.done) begin
            idx_q   <= IxW'(home);
            n_q     <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          if (n_q >= size || !used_q[idx_q]) begin
            if (kind_q == KIND_INSERT && n_q < size) begin
              used_q[idx_q] <= 1'b1;
              count_q <= count_q + 1'b1;
              st_q <= ST_OK;
              fs_q <= SlotW'(idx_q);
            end
            state_q <= S_RSP;
          end else if (rd_key_q == key_q) begin
            fs_q <= SlotW'(idx_q);
            if (kind_q == KIND_INSERT) st_q <= ST_PRESENT;
            else begin
              st_q <= ST_OK;
              if (kind_q == KIND_LOOKUP) rv_q <= ValueW'(rd_val_q);
              else begin
                used_q[idx_q] <= 1'b0;
                count_q <= count_q - 1'b1;
              end
            end
            state_q <= S_RSP;
          end else begin
            idx_q   <= nxt_idx;
            n_q     <= n_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_SLOT: begin
          if (32'(slot_q) < 32'(size) && used_q[IxW'(slot_q)]) begin
            st_q <= ST_OK;
            fs_q <= slot_q;
            if (kind_q == KIND_READ) rv_q <= ValueW'(rd_val_q);
            else begin
              used_q[IxW'(slot_q)] <= 1'b0;
              count_q <= count_q - 1'b1;
            end
          end
          state_q <= S_RSP;
        end
        S_RSP: if (rsp.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SzW'(Capacity)) else $error("count exceeds capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready && !cfg_we_i |=> $stable(rsp.status) && $stable(rsp.found_slot))
    else $error("result changed while held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.is_empty == (rsp.entry_total == '0))) else $error("empty flag");
endmodule

/* hdl/lpht_hash.sv */
// One character per cycle through a shared multiplier, then a restoring
// modulo of the 32-bit sum by the active size, one quotient bit per cycle.
module lpht_hash #(
  parameter int KeyChars = lpht_pkg::DefKeyChars,
  parameter int Capacity = lpht_pkg::DefCapacity
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [lpht_pkg::KeyW-1:0]          key_i,
  input  logic [$clog2(Capacity+1)-1:0]      size_i,
  output logic                               done_o,
  output logic [$clog2(Capacity+1)-1:0]      home_o
);
  import lpht_pkg::*;

  localparam int SzW  = $clog2(Capacity+1);
  localparam int ChW  = $clog2(KeyChars+1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [ChW-1:0]  chr_q, chr_d;
  logic [5:0]      bit_q, bit_d;
  logic [31:0]     sum_q, sum_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [32:0]     rem_q, rem_d;
  logic [32:0]     trial;
  logic            done_q;
  logic signed [8:0]  c;
  logic signed [31:0] term;

  assign c     = {key_q[7], key_q[7:0]};
  assign term  = 32'(2 * c * c) - 32'(c) + 32'sd3;
  assign trial = {rem_q[31:0], sum_q[31]};

  always_comb begin
    state_d = state_q;
    chr_d   = chr_q;
    bit_d   = bit_q;
    sum_d   = sum_q;
    key_d   = key_q;
    rem_d   = rem_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d   = key_i;
          sum_d   = '0;
          chr_d   = '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (key_q[7:0] == 8'd0 || chr_q == ChW'(KeyChars)) begin
          rem_d   = '0;
          bit_d   = '0;
          state_d = S_MOD;
        end else begin
          sum_d = sum_q + 32'(term);
          key_d = key_q >> 8;
          chr_d = chr_q + 1'b1;
        end
      end
      S_MOD: begin
        if (trial >= 33'(size_i)) rem_d = trial - 33'(size_i);
        else rem_d = trial;
        sum_d = sum_q << 1;
        bit_d = bit_q + 1'b1;
        if (bit_q == 6'd31) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // done pulses the cycle after the last quotient bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_MOD) && (bit_q == 6'd31);
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q <= chr_d;
    bit_q <= bit_d;
    sum_q <= sum_d;
    key_q <= key_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign home_o = SzW'(rem_q);
endmodule

/* sim/tb_pkg.sv */
`timescale 1ns / 1ps
package tb_pkg;
  import lpht_pkg::*;

  typedef struct {
    logic [KindW-1:0]  kind;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
    logic [SlotW-1:0]  slot;
    bit                cfg;
    logic [SizeW-1:0]  cfg_data;
  } op_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   found_slot;
    logic [ValueW-1:0]  read_value;
    logic [SizeW-1:0]   entry_total;
    logic               is_empty;
  } rsp_t;
endpackage

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import lpht_pkg::*;
  import tb_pkg::*;

  localparam int Cap = 64;
  localparam int CycleLimit = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SizeW-1:0] cfg_wdata_i = '0;

  lpht_req_if req ();
  lpht_rsp_if rsp ();

  linear_probe_hash_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req.sink), .rsp(rsp.source)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  int unsigned tbl_size;
  bit          used_q[Cap];
  logic [63:0] keys_q[Cap];
  logic [31:0] vals_q[Cap];
  int unsigned count_q;

  op_t  pending_ops[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_cfg = 0;
  int   cycles = 0;
  bit   quiet_mode = 1'b0;
  logic [63:0] key_pool[$];

  function automatic logic [63:0] trim_key(logic [63:0] k);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'd0) break;
      r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  function automatic int unsigned key_home(logic [63:0] k, int unsigned sz);
    logic [31:0] h;
    int c;
    h = '0;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'd0) break;
      c = $signed(k[8*i +: 8]);
      h = h + 32'(2 * c * c - c + 3);
    end
    return h % sz;
  endfunction

  function automatic bool_find(logic [63:0] k, output int unsigned where);
    int unsigned i;
    where = 0;
    i = key_home(k, tbl_size);
    for (int n = 0; n < tbl_size; n++) begin
      if (!used_q[i]) return 1'b0;
      if (keys_q[i] == k) begin
        where = i;
        return 1'b1;
      end
      i = (i + 1 >= tbl_size) ? 0 : i + 1;
    end
    return 1'b0;
  endfunction

  function automatic void resize_table(logic [SizeW-1:0] d);
    tbl_size = (d < 1) ? 1 : ((d > Cap) ? Cap : d);
    for (int i = 0; i < Cap; i++) used_q[i] = 1'b0;
    count_q = 0;
  endfunction

  function automatic rsp_t apply_op(op_t op);
    rsp_t r;
    logic [63:0] k;
    int unsigned i, w;
    k = trim_key(op.key);
    r.status = ST_MISS;
    r.found_slot = '0;
    r.read_value = '0;
    case (op.kind)
      KIND_INSERT: begin
        if (count_q >= tbl_size) r.status = ST_FULL;
        else begin
          i = key_home(k, tbl_size);
          for (int n = 0; n < tbl_size; n++) begin
            if (!used_q[i]) begin
              used_q[i] = 1'b1;
              keys_q[i] = k;
              vals_q[i] = op.value;
              count_q++;
              r.status = ST_OK;
              r.found_slot = SlotW'(i);
              break;
            end
            if (keys_q[i] == k) begin
              r.status = ST_PRESENT;
              r.found_slot = SlotW'(i);
              break;
            end
            i = (i + 1 >= tbl_size) ? 0 : i + 1;
          end
        end
      end
      KIND_LOOKUP: if (bool_find(k, w)) begin
        r.status = ST_OK;
        r.found_slot = SlotW'(w);
        r.read_value = vals_q[w];
      end
      KIND_DEL_KEY: if (bool_find(k, w)) begin
        used_q[w] = 1'b0;
        count_q--;
        r.status = ST_OK;
        r.found_slot = SlotW'(w);
      end
      KIND_READ: if (op.slot < tbl_size && used_q[op.slot]) begin
        r.status = ST_OK;
        r.found_slot = op.slot;
        r.read_value = vals_q[op.slot];
      end
      KIND_DEL_SLOT: if (op.slot < tbl_size && used_q[op.slot]) begin
        used_q[op.slot] = 1'b0;
        count_q--;
        r.status = ST_OK;
        r.found_slot = op.slot;
      end
      default: ;
    endcase
    r.entry_total = SizeW'(count_q);
    r.is_empty = (count_q == 0);
    return r;
  endfunction

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    int len;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return k;
      1: begin
        len = $urandom_range(0, 8);
        for (int i = 0; i < 8; i++) if (i >= len) k[8*i +: 8] = 8'd0;
        return k;
      end
      default: begin
        if (key_pool.size() == 0) return k;
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        // garbage after the terminator must not matter
        for (int i = 0; i < 8; i++) if (k[8*i +: 8] == 8'd0) begin
          if ($urandom_range(0, 1)) k = k | (64'({$urandom, $urandom}) << (8*i + 8));
          break;
        end
        return k;
      end
    endcase
  endfunction

  function automatic void push_op(logic [KindW-1:0] kd, logic [63:0] k, logic [31:0] v,
                                  logic [SlotW-1:0] s);
    op_t op;
    op.kind = kd; op.key = k; op.value = v; op.slot = s; op.cfg = 1'b0; op.cfg_data = '0;
    pending_ops.push_back(op);
    if (kd == KIND_INSERT && key_pool.size() < 200) key_pool.push_back(k);
  endfunction

  function automatic void push_cfg(logic [SizeW-1:0] d);
    op_t op;
    op.cfg = 1'b1; op.cfg_data = d; op.kind = '0; op.key = '0; op.value = '0; op.slot = '0;
    pending_ops.push_back(op);
  endfunction

  // driver: configuration writes wait for an idle block
  int cfg_hold = 0;
  always @(posedge clk_i) begin
    bit we;
    we = 1'b0;
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.kind  <= '0;
      req.key   <= '0;
      req.value <= '0;
      req.slot  <= '0;
      rsp.ready <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(apply_op(pending_ops.pop_front()));
        n_sent++;
      end
      if (!(req.valid && !req.ready)) begin
        if (pending_ops.size() > 0 && pending_ops[0].cfg && !req.valid) begin
          if (expected_rsps.size() == 0 && cfg_hold >= 400) begin
            we = 1'b1;
            cfg_wdata_i <= pending_ops[0].cfg_data;
            resize_table(pending_ops[0].cfg_data);
            void'(pending_ops.pop_front());
            n_cfg++;
            cfg_hold = 0;
          end else if (expected_rsps.size() == 0) cfg_hold++;
          else cfg_hold = 0;
          req.valid <= 1'b0;
        end else if (pending_ops.size() > 0 && !pending_ops[0].cfg &&
                     (quiet_mode || $urandom_range(0, 99) >= 24)) begin
          req.valid <= 1'b1;
          req.kind <= pending_ops[0].kind;
          req.key <= pending_ops[0].key;
          req.value <= pending_ops[0].value;
          req.slot <= pending_ops[0].slot;
        end else req.valid <= 1'b0;
      end
      rsp.ready <= quiet_mode || $urandom_range(0, 99) >= 24;
    end
    cfg_we_i <= we;
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response status=%0d slot=%0d", $time, rsp.status,
                 rsp.found_slot);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        n_checked++;
        if (rsp.status !== e.status || rsp.found_slot !== e.found_slot ||
            rsp.read_value !== e.read_value || rsp.entry_total !== e.entry_total ||
            rsp.is_empty !== e.is_empty) begin
          $display("%0t: mismatch exp st=%0d sl=%0d v=%h n=%0d e=%0b got st=%0d sl=%0d v=%h n=%0d e=%0b",
                   $time, e.status, e.found_slot, e.read_value, e.entry_total, e.is_empty,
                   rsp.status, rsp.found_slot, rsp.read_value, rsp.entry_total, rsp.is_empty);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               expected_rsps.size());
      $display("FAIL linear_probe_hash_table");
      $finish;
    end
  end

  initial begin
    int sizes[6] = '{1, 2, 7, 64, 100, 0};
    int sz;
    resize_table(7'd64);

    // directed
    push_op(KIND_INSERT, 64'h0, 32'hFFFF_FFFF, 0);            // empty key
    push_op(KIND_INSERT, 64'h0, 32'h1, 0);                    // already present
    push_op(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0);  // all negative chars
    push_op(KIND_INSERT, 64'h8000_0000_0000_0041, 32'h1234, 0);
    push_op(KIND_INSERT, 64'h7F7F_7F7F_7F7F_7F7F, 32'hA5A5_5A5A, 0);
    push_op(KIND_INSERT, 64'h0000_0000_0000_0041, 32'h77, 0); // collides by trim
    push_op(KIND_LOOKUP, 64'h0, 0, 0);
    push_op(KIND_LOOKUP, 64'h1234_0000_0000_0041, 0, 0);
    push_op(KIND_LOOKUP, 64'h42, 0, 0);                       // miss
    push_op(KIND_READ, 0, 0, 6'd63);
    push_op(KIND_READ, 0, 0, 6'd0);
    push_op(KIND_DEL_KEY, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    push_op(KIND_DEL_KEY, 64'h99, 0, 0);
    push_op(KIND_DEL_SLOT, 0, 0, 6'd63);
    push_op(KIND_DEL_SLOT, 0, 0, 6'd0);
    push_op(3'd5, 64'h1, 0, 0);
    push_op(3'd7, 64'h1, 0, 6'd5);
    push_cfg(7'd1);
    push_op(KIND_INSERT, 64'h31, 32'h5, 0);
    push_op(KIND_INSERT, 64'h32, 32'h6, 0);                   // full
    push_op(KIND_READ, 0, 0, 6'd1);                           // beyond size
    push_op(KIND_LOOKUP, 64'h32, 0, 0);                       // full wrap miss
    push_op(KIND_DEL_SLOT, 0, 0, 6'd0);

    // random phases over several sizes, extremes included
    for (int ph = 0; ph < 12; ph++) begin
      sz = (ph < 6) ? sizes[ph] : $urandom_range(0, 127);
      push_cfg(7'(sz));
      key_pool.delete();
      for (int n = 0; n < 160; n++) begin
        case ($urandom_range(0, 19))
          0,1,2,3,4,5,6: push_op(KIND_INSERT, rand_key(), $urandom, 6'($urandom));
          7,8,9,10: push_op(KIND_LOOKUP, rand_key(), $urandom, 6'($urandom));
          11,12,13: push_op(KIND_DEL_KEY, rand_key(), $urandom, 6'($urandom));
          14,15: push_op(KIND_READ, rand_key(), $urandom, 6'($urandom));
          16,17: push_op(KIND_DEL_SLOT, rand_key(), $urandom, 6'($urandom));
          default: push_op(3'($urandom_range(0, 7)), rand_key(), $urandom, 6'($urandom));
        endcase
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (30000) @(posedge clk_i);
    quiet_mode = 1'b1;  // stretch with no idling
    repeat (20000) @(posedge clk_i);
    quiet_mode = 1'b0;
    wait (pending_ops.size() == 0 && expected_rsps.size() == 0 && !req.valid);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d operations and %0d table resizes; %0d responses checked.",
             n_sent, n_cfg, n_checked);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS linear_probe_hash_table");
    end else begin
      $display("FAIL linear_probe_hash_table");
    end
    $finish;
  end
endmodule
